FILE: rtl/tcwc_pkg.sv
// Shared widths, reset values, event and register codes of the congestion window controller.
package tcwc_pkg;

  localparam int unsigned MssW  = 16;
  localparam int unsigned WinW  = 24;
  localparam int unsigned RtoW  = 27;
  localparam int unsigned ProdW = 2 * MssW;
  localparam int unsigned TypeW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DupW  = 2;

  localparam int unsigned DupAckLimitDefault = 3;

  localparam logic [MssW-1:0] SegmentSizeReset = MssW'(1124);
  localparam logic [WinW-1:0] InitThreshReset  = WinW'(64000);
  localparam logic [WinW-1:0] RcvWindowReset   = WinW'(65535);
  localparam logic [WinW-1:0] WinMax           = {WinW{1'b1}};

  typedef enum logic [TypeW-1:0] {
    REQ_START   = 3'd0,
    REQ_NEW_ACK = 3'd1,
    REQ_DUP_ACK = 3'd2,
    REQ_TIMEOUT = 3'd3,
    REQ_RTT     = 3'd4
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEGMENT_SIZE = 2'd0,
    CFG_INIT_THRESH  = 2'd1,
    CFG_RCV_WINDOW   = 2'd2
  } cfg_idx_e;

endpackage

FILE: rtl/tcwc_if.sv
// Channel interfaces of the congestion window controller: config write, event, result.
interface tcwc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tcwc_pkg::CfgIdxW-1:0]  index;
  logic [tcwc_pkg::WinW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface tcwc_req_if;
  logic                        valid;
  logic                        ready;
  logic [tcwc_pkg::TypeW-1:0]  req_type;
  logic [tcwc_pkg::WinW-1:0]   rtt_sample_us;

  modport source (output valid, req_type, rtt_sample_us, input ready);
  modport sink   (input valid, req_type, rtt_sample_us, output ready);
endinterface

interface tcwc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [tcwc_pkg::WinW-1:0]  congestion_window;
  logic [tcwc_pkg::WinW-1:0]  slow_start_threshold;
  logic [tcwc_pkg::WinW-1:0]  usable_window;
  logic [tcwc_pkg::RtoW-1:0]  retransmit_timeout_us;
  logic                       fast_retransmit;
  logic                       in_slow_start;

  modport source (output valid, congestion_window, slow_start_threshold, usable_window,
                  retransmit_timeout_us, fast_retransmit, in_slow_start, input ready);
  modport sink   (input valid, congestion_window, slow_start_threshold, usable_window,
                  retransmit_timeout_us, fast_retransmit, in_slow_start, output ready);
endinterface

FILE: rtl/tcp_congestion_window_control_core.sv
// Top level of the Reno congestion window controller with a smoothed RTT estimator.
//
// Usage: the sender posts one event per item on req_i (start, new ack, duplicate ack,
// timeout, RTT sample) and receives exactly one result item on rsp_o: window,
// threshold, usable window, retransmission timeout and two flags.
// Configuration (segment size, initial threshold, receiver window) is written on cfg_i,
// which is always ready; write it only while no event is in flight.
// Steps: most events go from idle straight to the output step, an RTT sample passes the
// smoothed-mean and deviation steps first, and a new ack in congestion avoidance loads the
// restoring divider, which forms MSS*MSS/window at one quotient bit per cycle, before
// the output step.
// One event is in work at a time; req_i.ready is high only while the sequencer is idle,
// so a new event is taken only once the last one has left the output step.
// The result sits in an output register: a new event is taken while it waits, and a
// finished event holds in the last step until the receiver takes the earlier result.
// Reset: window, duplicate count and RTT state clear, the threshold takes 64000 and the
// registers take their defaults; no result is pending.
module tcp_congestion_window_control_core #(
  parameter int unsigned DUP_ACK_LIMIT = tcwc_pkg::DupAckLimitDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tcwc_cfg_if.sink     cfg_i,
  tcwc_req_if.sink     req_i,
  tcwc_rsp_if.source   rsp_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_RTT_S = 6'b001000,
    ST_RTT_D = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [tcwc_pkg::MssW-1:0] mss_q;
  logic [tcwc_pkg::WinW-1:0] init_thr_q;
  logic [tcwc_pkg::WinW-1:0] rwnd_q;

  // controller state
  logic [tcwc_pkg::WinW-1:0] win_q, win_d;
  logic [tcwc_pkg::WinW-1:0] thr_q, thr_d;
  logic [tcwc_pkg::DupW-1:0] dup_q, dup_d;
  logic [tcwc_pkg::WinW-1:0] srtt_q, srtt_d;
  logic [tcwc_pkg::WinW-1:0] dev_q, dev_d;
  logic [tcwc_pkg::RtoW-1:0] rto_q, rto_d;
  logic                      fast_d;

  // latched event
  logic [tcwc_pkg::TypeW-1:0]  type_q;
  logic [tcwc_pkg::WinW-1:0]   sample_q;
  logic [tcwc_pkg::ProdW-1:0]  prod_q;

  // result register
  logic                      rsp_valid_q;
  logic [tcwc_pkg::WinW-1:0] rsp_cwnd_q, rsp_thr_q, rsp_usable_q;
  logic [tcwc_pkg::RtoW-1:0] rsp_rto_q;
  logic                      rsp_fast_q, rsp_slow_q;

  logic                      req_fire;
  logic                      out_fire;
  logic                      need_div;
  logic                      div_done;
  logic [tcwc_pkg::ProdW-1:0] quotient;

  logic [tcwc_pkg::ProdW:0]   ack_sum;
  logic [tcwc_pkg::ProdW-1:0] ack_inc;
  logic [tcwc_pkg::WinW-1:0]  half_win;
  logic [tcwc_pkg::WinW:0]    fr_sum;
  logic [tcwc_pkg::DupW-1:0]  dup_inc;
  logic [tcwc_pkg::RtoW:0]    srtt_sum;
  logic [tcwc_pkg::WinW-1:0]  abs_diff;
  logic [tcwc_pkg::RtoW-1:0]  dev_sum;
  logic [tcwc_pkg::RtoW-1:0]  rto_sum;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_fire    = (state_q == ST_OUT) && (!rsp_valid_q || rsp_o.ready);

  // congestion avoidance step needs MSS*MSS/window
  assign need_div = (win_q >= thr_q) && (win_q != '0);

  tcwc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_LOAD),
    .dividend_i (prod_q),
    .divisor_i  (win_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (req_i.req_type == tcwc_pkg::REQ_NEW_ACK && need_div) begin
            state_d = ST_LOAD;
          end else if (req_i.req_type == tcwc_pkg::REQ_RTT) begin
            state_d = ST_RTT_S;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_LOAD:  state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_OUT;
      ST_RTT_S: state_d = ST_RTT_D;
      ST_RTT_D: state_d = ST_OUT;
      ST_OUT:   if (out_fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // RTT estimator steps: smoothed first, then deviation against the new mean
  always_comb begin
    srtt_sum = {1'b0, srtt_q, 3'b0} - {4'b0, srtt_q} + {4'b0, sample_q};
    srtt_d   = srtt_sum[tcwc_pkg::WinW+2:3];
    abs_diff = (sample_q >= srtt_q) ? (sample_q - srtt_q) : (srtt_q - sample_q);
    dev_sum  = {2'b0, dev_q, 1'b0} + {3'b0, dev_q} + {3'b0, abs_diff};
    dev_d    = dev_sum[tcwc_pkg::WinW+1:2];
    rto_sum  = {3'b0, srtt_q} + {1'b0, dev_q, 2'b0};
  end

  // event update applied when the result is loaded
  always_comb begin
    win_d    = win_q;
    thr_d    = thr_q;
    dup_d    = dup_q;
    rto_d    = rto_q;
    fast_d   = 1'b0;
    half_win = win_q >> 1;
    dup_inc  = dup_q + 1'b1;
    ack_inc  = need_div ? quotient : {{(tcwc_pkg::ProdW - tcwc_pkg::MssW){1'b0}}, mss_q};
    ack_sum  = {{(tcwc_pkg::ProdW + 1 - tcwc_pkg::WinW){1'b0}}, win_q} + {1'b0, ack_inc};
    fr_sum   = {1'b0, half_win} + {1'b0, 8'b0, mss_q} + {1'b0, 7'b0, mss_q, 1'b0};
    case (type_q)
      tcwc_pkg::REQ_START: begin
        win_d = {8'b0, mss_q};
        thr_d = init_thr_q;
        dup_d = '0;
        rto_d = '0;
      end
      tcwc_pkg::REQ_NEW_ACK: begin
        dup_d = '0;
        win_d = (ack_sum > {{(tcwc_pkg::ProdW + 1 - tcwc_pkg::WinW){1'b0}}, tcwc_pkg::WinMax})
                ? tcwc_pkg::WinMax : ack_sum[tcwc_pkg::WinW-1:0];
      end
      tcwc_pkg::REQ_DUP_ACK: begin
        if (dup_inc == tcwc_pkg::DupW'(DUP_ACK_LIMIT)) begin
          dup_d  = '0;
          thr_d  = half_win;
          win_d  = fr_sum[tcwc_pkg::WinW] ? tcwc_pkg::WinMax : fr_sum[tcwc_pkg::WinW-1:0];
          fast_d = 1'b1;
        end else begin
          dup_d = dup_inc;
        end
      end
      tcwc_pkg::REQ_TIMEOUT: begin
        thr_d = half_win;
        win_d = {8'b0, mss_q};
      end
      tcwc_pkg::REQ_RTT: begin
        rto_d = (rto_sum[tcwc_pkg::RtoW-1:0] == '0) ? tcwc_pkg::RtoW'(1)
                                                    : rto_sum[tcwc_pkg::RtoW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mss_q       <= tcwc_pkg::SegmentSizeReset;
      init_thr_q  <= tcwc_pkg::InitThreshReset;
      rwnd_q      <= tcwc_pkg::RcvWindowReset;
      win_q       <= '0;
      thr_q       <= tcwc_pkg::InitThreshReset;
      dup_q       <= '0;
      srtt_q      <= '0;
      dev_q       <= '0;
      rto_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          tcwc_pkg::CFG_SEGMENT_SIZE: mss_q      <= cfg_i.data[tcwc_pkg::MssW-1:0];
          tcwc_pkg::CFG_INIT_THRESH:  init_thr_q <= cfg_i.data;
          tcwc_pkg::CFG_RCV_WINDOW:   rwnd_q     <= cfg_i.data;
          default: begin
          end
        endcase
      end
      if (state_q == ST_RTT_S) begin
        srtt_q <= srtt_d;
      end
      if (state_q == ST_RTT_D) begin
        dev_q <= dev_d;
      end
      if (out_fire) begin
        win_q <= win_d;
        thr_q <= thr_d;
        dup_q <= dup_d;
        rto_q <= rto_d;
        if (type_q == tcwc_pkg::REQ_START) begin
          srtt_q <= '0;
          dev_q  <= '0;
        end
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      type_q   <= req_i.req_type;
      sample_q <= req_i.rtt_sample_us;
      prod_q   <= tcwc_pkg::ProdW'(mss_q) * tcwc_pkg::ProdW'(mss_q);
    end
    if (out_fire) begin
      rsp_cwnd_q   <= win_d;
      rsp_thr_q    <= thr_d;
      rsp_usable_q <= (win_d < rwnd_q) ? win_d : rwnd_q;
      rsp_rto_q    <= (rto_d == '0) ? tcwc_pkg::RtoW'(1) : rto_d;
      rsp_fast_q   <= fast_d;
      rsp_slow_q   <= (win_d < thr_d);
    end
  end

  assign rsp_o.valid                 = rsp_valid_q;
  assign rsp_o.congestion_window     = rsp_cwnd_q;
  assign rsp_o.slow_start_threshold  = rsp_thr_q;
  assign rsp_o.usable_window         = rsp_usable_q;
  assign rsp_o.retransmit_timeout_us = rsp_rto_q;
  assign rsp_o.fast_retransmit       = rsp_fast_q;
  assign rsp_o.in_slow_start         = rsp_slow_q;

endmodule

FILE: rtl/tcwc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module tcwc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tcwc_pkg::ProdW-1:0]    dividend_i,
  input  logic [tcwc_pkg::WinW-1:0]     divisor_i,
  output logic                          done_o,
  output logic [tcwc_pkg::ProdW-1:0]    quotient_o
);

  localparam int unsigned CntW = $clog2(tcwc_pkg::ProdW);

  logic                          busy_q;
  logic                          done_q;
  logic [CntW-1:0]               cnt_q;
  logic [tcwc_pkg::WinW-1:0]     rem_q, rem_d;
  logic [tcwc_pkg::WinW-1:0]     dvs_q;
  logic [tcwc_pkg::ProdW-1:0]    quo_q;
  logic [tcwc_pkg::WinW:0]       trial;
  logic [tcwc_pkg::WinW:0]       trial_sub;
  logic                          ge;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial     = {rem_q, quo_q[tcwc_pkg::ProdW-1]};
    trial_sub = trial - {1'b0, dvs_q};
    ge        = (trial >= {1'b0, dvs_q});
    rem_d     = ge ? trial_sub[tcwc_pkg::WinW-1:0] : trial[tcwc_pkg::WinW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(tcwc_pkg::ProdW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[tcwc_pkg::ProdW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
